FILE: src/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg: shared types for the sorted list merge unit
// Value type, controller state encoding, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package slm_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PREP,
      ST_MERGE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // input beats may be taken and appended
      logic prep;   // rewind both read pointers
      logic merge;  // emit merged results
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic eos_seen;    // a beat with end_of_set was taken this cycle
      logic merge_done;  // the final result of the run was issued this cycle
   } sts_type;

endpackage

FILE: src/slm_req_if.sv
// ----------------------------------------------------------------------------
// slm_req_if: element input channel
// Valid/ready channel that carries one list element per beat.
// ----------------------------------------------------------------------------
interface slm_req_if import slm_pkg::*; ();

   logic      valid;
   logic      ready;
   logic      mode;
   value_type value;
   logic      end_of_set;

   modport source (output valid, output mode, output value, output end_of_set,
                   input ready);
   modport sink   (input valid, input mode, input value, input end_of_set,
                   output ready);

endinterface

FILE: src/slm_rsp_if.sv
// ----------------------------------------------------------------------------
// slm_rsp_if: merged result channel
// Valid/ready channel that carries one merged element per beat.
// ----------------------------------------------------------------------------
interface slm_rsp_if import slm_pkg::*; ();

   logic      valid;
   logic      ready;
   value_type merged_value;
   logic      last;
   logic      dropped;

   modport source (output valid, output merged_value, output last, output dropped,
                   input ready);
   modport sink   (input valid, input merged_value, input last, input dropped,
                   output ready);

endinterface

FILE: src/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl: merge unit controller
// Sequences the load, pointer rewind and merge phases.
// ----------------------------------------------------------------------------
module slm_ctrl import slm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.eos_seen) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (sts.merge_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

FILE: src/slm_datapath.sv
// ----------------------------------------------------------------------------
// slm_datapath: list storage and merge datapath
// Two list memories with registered reads, fill counts, read pointers, the
// merge compare and the result output register.
// ----------------------------------------------------------------------------
module slm_datapath import slm_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   slm_req_if.sink      req,
   slm_rsp_if.source    rsp,
   input  cmd_type      cmd,
   output sts_type      sts
);

   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

   value_type first_mem  [LIST_DEPTH];
   value_type second_mem [LIST_DEPTH];

   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic [CW-1:0] idx_a_plus, idx_b_plus;
   logic          ovf_ff, ovf_in;
   value_type     head_a_ff, head_b_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   value_type     rsp_value_ff;
   logic          rsp_last_ff, rsp_drop_ff;

   logic accept, wr_a, wr_b, full_drop;
   logic a_has, b_has, take_a, last_pick, fire;

   // Load side.
   assign accept    = req.valid && cmd.load;
   assign wr_a      = accept && !req.mode && (cnt_a_ff < DEPTH_C);
   assign wr_b      = accept &&  req.mode && (cnt_b_ff < DEPTH_C);
   assign full_drop = accept && !wr_a && !wr_b;

   // Merge side: while merging, the heads hold the entries under the read pointers.
   assign a_has      = (idx_a_ff != cnt_a_ff);
   assign b_has      = (idx_b_ff != cnt_b_ff);
   assign take_a     = a_has && (!b_has || (head_a_ff <= head_b_ff));
   assign idx_a_plus = idx_a_ff + 1'b1;
   assign idx_b_plus = idx_b_ff + 1'b1;
   assign last_pick  = take_a ? ((idx_a_plus == cnt_a_ff) && !b_has)
                              : ((idx_b_plus == cnt_b_ff) && !a_has);
   assign fire       = cmd.merge && (!rsp_valid_ff || rsp.ready);

   assign sts.eos_seen   = accept && req.end_of_set;
   assign sts.merge_done = fire && last_pick;

   always_comb begin
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ovf_in   = ovf_ff;
      if (sts.merge_done) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (wr_a) begin
            cnt_a_in = cnt_a_ff + 1'b1;
         end
         if (wr_b) begin
            cnt_b_in = cnt_b_ff + 1'b1;
         end
         if (full_drop) begin
            ovf_in = 1'b1;
         end
      end
   end

   always_comb begin
      idx_a_in = idx_a_ff;
      idx_b_in = idx_b_ff;
      if (cmd.prep) begin
         idx_a_in = '0;
         idx_b_in = '0;
      end else if (fire) begin
         if (take_a) begin
            idx_a_in = idx_a_plus;
         end else begin
            idx_b_in = idx_b_plus;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // List memories: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (wr_a) begin
         first_mem[cnt_a_ff[AW-1:0]] <= req.value;
      end
      head_a_ff <= first_mem[idx_a_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         second_mem[cnt_b_ff[AW-1:0]] <= req.value;
      end
      head_b_ff <= second_mem[idx_b_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_value_ff <= take_a ? head_a_ff : head_b_ff;
         rsp_last_ff  <= last_pick;
         rsp_drop_ff  <= ovf_ff;
      end
   end

   assign req.ready        = cmd.load;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.merged_value = rsp_value_ff;
   assign rsp.last         = rsp_last_ff;
   assign rsp.dropped      = rsp_drop_ff;

   // While merging, the read pointers never run past the fill counts.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> (idx_a_ff <= cnt_a_ff) && (idx_b_ff <= cnt_b_ff))
      else $error("read pointer beyond fill count");

   // Fill counts stay within the list capacity.
   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= DEPTH_C) && (cnt_b_ff <= DEPTH_C))
      else $error("fill count beyond capacity");

   // A finished run leaves both lists empty and the drop flag clear.
   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      sts.merge_done |=> (cnt_a_ff == '0) && (cnt_b_ff == '0) && !ovf_ff)
      else $error("state not cleared after run");

   // A result is only issued while there is something left to merge.
   a_fire_has_data: assert property (@(posedge clock) disable iff (reset)
      fire |-> (a_has || b_has))
      else $error("result issued with both lists exhausted");

endmodule

FILE: src/sorted_list_merge_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_merge_unit: two-way merge of two sorted lists
// Stores two ascending lists of signed values and streams their merge.
// ----------------------------------------------------------------------------
// The req_bus channel takes one element per beat. The mode field picks the
// list (0 first, 1 second) and elements are appended in arrival order. Each
// list holds LIST_DEPTH entries; an element for a full list is discarded and
// every result of that run then carries dropped.
// The beat with end_of_set is stored like any other and starts the merge.
// req_bus.ready is high in every cycle of the load phase, so elements load
// at one per cycle. From the edge that takes the end_of_set beat until the
// final result enters the output register, ready stays low.
// After that edge the controller rewinds both read pointers, and the merge
// state then moves results into the output register that drives rsp_bus; one
// result is produced per cycle while rsp_bus keeps up, set by the single read
// port of each list memory and the one compare between the two list heads.
// Results are ascending; on equal values the first list's element goes first.
// The final result carries last. The output register holds a result until
// rsp_bus.ready takes it, and a stalled receiver simply pauses the merge.
// Loading of the next set may start while the final result still waits.
// Reset empties both lists and clears the drop flag and the output channel.
// ----------------------------------------------------------------------------
module sorted_list_merge_unit import slm_pkg::*; #(
   parameter int LIST_DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   slm_req_if.sink   req_bus,
   slm_rsp_if.source rsp_bus
);

   cmd_type cmd;
   sts_type sts;

   // The controller steps through load, pointer rewind and merge.
   slm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // The datapath owns both list memories and the result register.
   slm_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .cmd   (cmd),
      .sts   (sts)
   );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_list_merge_unit
// Loads sets of elements into the two lists, predicts the merged stream of
// every set, and compares each result beat against that prediction while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import slm_pkg::*;

   localparam int LIST_DEPTH = 32;

   // One expected result beat.
   typedef struct {
      value_type merged_value;
      logic      last;
      logic      dropped;
   } merged_type;

   // One row of the directed plan. Rows with typed set carry their expected
   // result here; all others are checked against the merge predictor.
   typedef struct {
      logic      mode;
      value_type value;
      logic      eos;
      bit        typed;
      value_type exp_value;
      logic      exp_dropped;
   } plan_type;

   logic clock;
   logic reset;

   slm_req_if req_bus ();
   slm_rsp_if rsp_bus ();

   sorted_list_merge_unit #(
      .LIST_DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Predictor state: the two lists as the block should hold them.
   value_type  first_list [LIST_DEPTH];
   value_type  second_list [LIST_DEPTH];
   logic [5:0] first_count;
   logic [5:0] second_count;
   logic       overflow_seen;

   // Merged beats still to come, oldest first.
   merged_type merged_due [$];

   // Idle percentages of the two sides and the receiver hold-off request.
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_off_left;

   // Run statistics.
   int elements_sent;
   int sets_sent;
   int results_seen;
   int dropped_seen;
   int mismatch_count;

   // The directed plan: extremes of the value field, a single element in
   // each list alone, a tie between the lists, the first list running out
   // while the second still holds elements and the reverse, and a set loaded
   // out of order, which the block merges without checking.
   plan_type plan [19] = '{
      '{1'b0, 32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff, 1'b0},
      '{1'b1, 32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b0},
      '{1'b1, 32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 1'b0},
      '{1'b0, 32'shffffffff, 1'b1, 1'b1, 32'shffffffff, 1'b0},
      '{1'b0, -32'sd5,       1'b0, 1'b0, '0, 1'b0},
      '{1'b1, -32'sd5,       1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 32'sd3,        1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 32'sd0,        1'b1, 1'b0, '0, 1'b0},
      '{1'b0, -32'sd10,      1'b0, 1'b0, '0, 1'b0},
      '{1'b1, -32'sd1,       1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 32'sd5,        1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 32'sh7fffffff, 1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 32'sd1,        1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 32'sd2,        1'b0, 1'b0, '0, 1'b0},
      '{1'b0, 32'sd3,        1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 32'sd0,        1'b1, 1'b0, '0, 1'b0},
      '{1'b0, 32'sd5,        1'b0, 1'b0, '0, 1'b0},
      '{1'b0, -32'sd3,       1'b0, 1'b0, '0, 1'b0},
      '{1'b1, 32'sd1,        1'b1, 1'b0, '0, 1'b0}
   };

   // Clock with a period of 10.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Two-pointer merge of whatever the lists hold. Every beat of the run
   // carries the drop flag; the final one carries last. Afterwards both
   // lists and the flag are cleared for the next set.
   function automatic void merge_lists(input bit queue_beats);
      int         rd_first;
      int         rd_second;
      int         total;
      value_type  pick;
      merged_type beat;
      rd_first  = 0;
      rd_second = 0;
      total     = first_count + second_count;
      for (int k = 0; k < total; k++) begin
         if (rd_first < first_count && rd_second < second_count) begin
            if (first_list[rd_first] <= second_list[rd_second]) begin
               pick = first_list[rd_first++];
            end else begin
               pick = second_list[rd_second++];
            end
         end else if (rd_first < first_count) begin
            pick = first_list[rd_first++];
         end else begin
            pick = second_list[rd_second++];
         end
         beat.merged_value = pick;
         beat.last         = (k + 1 == total);
         beat.dropped      = overflow_seen;
         if (queue_beats) begin
            merged_due.push_back(beat);
         end
      end
      first_count   = '0;
      second_count  = '0;
      overflow_seen = 1'b0;
   endfunction

   // Appends one accepted element to its list, or notes the drop when the
   // list is full. The end-of-set element is treated the same way before it
   // starts the merge.
   function automatic void store_element(input logic mode, input value_type value,
                                         input logic eos, input bit queue_beats);
      if (mode == 1'b0) begin
         if (first_count < LIST_DEPTH) begin
            first_list[first_count] = value;
            first_count++;
         end else begin
            overflow_seen = 1'b1;
         end
      end else begin
         if (second_count < LIST_DEPTH) begin
            second_list[second_count] = value;
            second_count++;
         end else begin
            overflow_seen = 1'b1;
         end
      end
      if (eos) begin
         merge_lists(queue_beats);
         sets_sent++;
      end
   endfunction

   // Offers one element, starting and ending at a falling edge. Idle cycles
   // are inserted ahead of the beat at the current sender rate, and the beat
   // stays on the bus until a rising edge sees ready.
   task automatic offer_element(input logic mode, input value_type value,
                                input logic eos, input bit queue_beats);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.mode       = mode;
      req_bus.value      = value;
      req_bus.end_of_set = eos;
      do @(posedge clock); while (!req_bus.ready);
      store_element(mode, value, eos, queue_beats);
      elements_sent++;
      @(negedge clock);
   endtask

   // One random set. Most sets are short ascending lists; some are loaded
   // out of order, and some fill one or both lists up to and past capacity,
   // at times with the end-of-set element itself landing on a full list.
   // Half the sets draw from a narrow range so that ties between the lists
   // are common.
   task automatic send_random_set();
      value_type first_vals [$];
      value_type second_vals [$];
      value_type eos_value;
      int        kind;
      int        n_first;
      int        n_second;
      logic      eos_list;
      logic      pick_list;
      bit        narrow;
      kind   = $urandom_range(99);
      narrow = $urandom_range(1);
      if (kind < 65) begin
         n_first  = $urandom_range(6);
         n_second = $urandom_range(6);
      end else if (kind < 75) begin
         n_first  = $urandom_range(1, 6);
         n_second = $urandom_range(1, 6);
      end else if (kind < 92) begin
         n_first  = $urandom_range(4);
         n_second = $urandom_range(28, 36);
         if ($urandom_range(1)) begin
            n_first  = n_second;
            n_second = $urandom_range(4);
         end
      end else begin
         n_first  = $urandom_range(30, 34);
         n_second = $urandom_range(30, 34);
      end
      eos_list = $urandom_range(1);
      if (eos_list == 1'b0 && n_first == 0) begin
         n_first = 1;
      end
      if (eos_list == 1'b1 && n_second == 0) begin
         n_second = 1;
      end
      repeat (n_first) begin
         first_vals.push_back(narrow ? value_type'(int'($urandom_range(31)) - 16)
                                     : value_type'($urandom));
      end
      repeat (n_second) begin
         second_vals.push_back(narrow ? value_type'(int'($urandom_range(31)) - 16)
                                      : value_type'($urandom));
      end
      if (kind >= 65 && kind < 75) begin
         first_vals.shuffle();
         second_vals.shuffle();
      end else begin
         first_vals.sort();
         second_vals.sort();
      end
      // The end-of-set element is the last one of its list.
      eos_value = (eos_list == 1'b0) ? first_vals.pop_back() : second_vals.pop_back();
      while (first_vals.size() != 0 || second_vals.size() != 0) begin
         if (first_vals.size() != 0 && second_vals.size() != 0) begin
            pick_list = $urandom_range(1);
         end else begin
            pick_list = (first_vals.size() == 0);
         end
         if (pick_list == 1'b0) begin
            offer_element(1'b0, first_vals.pop_front(), 1'b0, 1'b1);
         end else begin
            offer_element(1'b1, second_vals.pop_front(), 1'b0, 1'b1);
         end
      end
      offer_element(eos_list, eos_value, 1'b1, 1'b1);
   endtask

   // Receiver: picks ready at every falling edge. A pending hold-off keeps
   // ready low until hold_off_left has counted down to zero, regardless of the idle rate.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_off_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Result checker: every beat taken at a rising edge is compared with the
   // oldest expectation. A beat with nothing expected is a failure as well.
   always @(posedge clock) begin : check_results
      merged_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.dropped === 1'b1) begin
            dropped_seen++;
         end
         if (merged_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result beat: value %0d last %b dropped %b",
                        rsp_bus.merged_value, rsp_bus.last, rsp_bus.dropped);
            end
         end else begin
            due = merged_due.pop_front();
            if (rsp_bus.merged_value !== due.merged_value || rsp_bus.last !== due.last ||
                rsp_bus.dropped !== due.dropped) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d mismatch: expected value %0d last %b dropped %b,",
                           results_seen, due.merged_value, due.last, due.dropped);
                  $display("   got value %0d last %b dropped %b",
                           rsp_bus.merged_value, rsp_bus.last, rsp_bus.dropped);
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.mode       = 1'b0;
      req_bus.value      = '0;
      req_bus.end_of_set = 1'b0;
      tx_idle_pct        = 16;
      rx_idle_pct        = 62;
      hold_off_left      = 0;
      elements_sent      = 0;
      sets_sent          = 0;
      results_seen       = 0;
      dropped_seen       = 0;
      mismatch_count     = 0;
      first_count        = '0;
      second_count       = '0;
      overflow_seen      = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Typed rows are single-element sets, so their one
      // result is also the last one; the predictor state still advances.
      foreach (plan[r]) begin
         offer_element(plan[r].mode, plan[r].value, plan[r].eos, !plan[r].typed);
         if (plan[r].typed) begin
            merged_due.push_back('{plan[r].exp_value, 1'b1, plan[r].exp_dropped});
         end
      end

      // Random part, first phase: slow receiver. It starts with a long
      // hold-off while the sender keeps loading, so a merge backs up into
      // the output register and the input stays stalled.
      hold_off_left = 300;
      while (elements_sent < 150) begin
         send_random_set();
      end

      // Second phase: the sender pauses until every beat has drained, then
      // the idle rates swap.
      req_bus.valid = 1'b0;
      wait (merged_due.size() == 0);
      @(negedge clock);
      tx_idle_pct = 62;
      rx_idle_pct = 16;
      while (elements_sent < 290) begin
         send_random_set();
      end

      // Third phase: neither side idles.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      while (elements_sent < 420) begin
         send_random_set();
      end
      req_bus.valid = 1'b0;

      // Drain, then allow a few more cycles for any stray beat.
      wait (merged_due.size() == 0);
      repeat (20) @(posedge clock);

      $display("loaded %0d elements in %0d sets and checked %0d merged beats,",
               elements_sent, sets_sent, results_seen);
      $display("%0d of them flagged dropped, %0d mismatches", dropped_seen, mismatch_count);
      if (mismatch_count == 0 && merged_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("timeout waiting for the merge unit");
      $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
src/slm_pkg.sv
src/slm_req_if.sv
src/slm_rsp_if.sv
src/slm_ctrl.sv
src/slm_datapath.sv
src/sorted_list_merge_unit.sv
tb/testbench.sv
